// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the particle push checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define PP1D_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define PP1D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pp1d_pkg.sv =====
// ----------------------------------------------------------------------------
// pp1d_pkg
// widths, codes and queue word type for the 1d particle push
// ----------------------------------------------------------------------------
`default_nettype none

package pp1d_pkg;

  localparam int CMD_W      = 2;
  localparam int NODE_IDX_W = 9;
  localparam int FIELD_W    = 32;
  localparam int POS_W      = 25;
  localparam int FRAC_W     = 16;
  localparam int VEL_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int NODES_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NODE_COUNT_DEF = 512;
  localparam int MIN_NODES      = 2;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [NODES_W-1:0]   NODES_RESET      = 10'd401;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES_IN_USE = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_PUSH,
    KIND_REWIND,
    KIND_PASS
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [NODE_IDX_W-1:0]        node_index;
    logic signed [FIELD_W-1:0]    field_value;
    logic [POS_W-1:0]             position;
    logic signed [VEL_W-1:0]      velocity;
  } q_word_t;

  // width that holds both the node count register and the table depth
  function automatic int node_cnt_w(input int node_count);
    int w;
    w = $clog2(node_count + 1);
    return (w > NODES_W) ? w : NODES_W;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pp1d_if.sv =====
// ----------------------------------------------------------------------------
// pp1d_if
// valid/ready channels for particle words and push results
// ----------------------------------------------------------------------------
`default_nettype none

interface pp1d_item_if;
  import pp1d_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [NODE_IDX_W-1:0]      node_index;
  logic signed [FIELD_W-1:0]  field_value;
  logic [POS_W-1:0]           position;
  logic signed [VEL_W-1:0]    velocity;

  modport source (
    output valid, cmd, node_index, field_value, position, velocity,
    input  ready
  );

  modport sink (
    input  valid, cmd, node_index, field_value, position, velocity,
    output ready
  );
endinterface

interface pp1d_result_if;
  import pp1d_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         new_position;
  logic signed [VEL_W-1:0]  new_velocity;
  logic                     absorbed;

  modport source (
    output valid, new_position, new_velocity, absorbed,
    input  ready
  );

  modport sink (
    input  valid, new_position, new_velocity, absorbed,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/pp1d_front.sv =====
// ----------------------------------------------------------------------------
// pp1d_front
// accepts words, sorts them by command and domain, and queues them in order
// ----------------------------------------------------------------------------
`default_nettype none

module pp1d_front #(
  parameter int NODE_COUNT = pp1d_pkg::NODE_COUNT_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  pp1d_item_if.sink                                      item,
  input  logic [pp1d_pkg::NODES_W-1:0]                   nodes_in_use,
  output logic [pp1d_pkg::node_cnt_w(NODE_COUNT)-1:0]    last_node,
  output pp1d_pkg::q_word_t                              head,
  output logic                                           head_valid,
  input  logic                                           pop
);
  import pp1d_pkg::*;

  localparam int CW = node_cnt_w(NODE_COUNT);
  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [CW-1:0] nodes_ext;
  logic [CW-1:0] nodes_clamp;
  logic          outside;
  logic          node_ok;
  logic          keep;
  logic          push;
  kind_t         kind;
  q_word_t       word_in;

  q_word_t       words [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic [PW:0]   count_next;

  // active node count clamped to the table
  always_comb begin
    nodes_ext = CW'(nodes_in_use);
    if (nodes_ext < CW'(MIN_NODES)) begin
      nodes_clamp = CW'(MIN_NODES);
    end else if (nodes_ext > CW'(NODE_COUNT)) begin
      nodes_clamp = CW'(NODE_COUNT);
    end else begin
      nodes_clamp = nodes_ext;
    end
    last_node = nodes_clamp - CW'(1);
  end

  assign outside = CW'(item.position[POS_W-1:FRAC_W]) >= last_node;
  assign node_ok = int'(item.node_index) < NODE_COUNT;

  always_comb begin
    keep = 1'b0;
    kind = KIND_PASS;
    unique case (cmd_t'(item.cmd)) inside
      CMD_WRITE: begin
        keep = node_ok;
        kind = KIND_WRITE;
      end
      CMD_PUSH, CMD_REWIND: begin
        keep = 1'b1;
        if (outside) begin
          kind = KIND_PASS;
        end else if (cmd_t'(item.cmd) == CMD_PUSH) begin
          kind = KIND_PUSH;
        end else begin
          kind = KIND_REWIND;
        end
      end
      default: begin
        keep = 1'b0;
        kind = KIND_PASS;
      end
    endcase
  end

  assign word_in = '{
    kind:        kind,
    node_index:  item.node_index,
    field_value: item.field_value,
    position:    item.position,
    velocity:    item.velocity
  };

  assign item.ready = count != (PW+1)'(QUEUE_DEPTH);
  assign push       = item.valid && item.ready && keep;
  assign head_valid = count != '0;
  assign head       = words[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + (PW+1)'(1);
      2'b01:   count_next = count - (PW+1)'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      words[wr_ptr] <= word_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pp1d_back.sv =====
// ----------------------------------------------------------------------------
// pp1d_back
// field table and push pipeline: gather, kick, drift, absorb, output word
// ----------------------------------------------------------------------------
`default_nettype none

module pp1d_back #(
  parameter int NODE_COUNT = pp1d_pkg::NODE_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  pp1d_pkg::q_word_t                             head,
  input  logic                                          head_valid,
  output logic                                          pop,
  input  logic signed [pp1d_pkg::GAIN_W-1:0]            accel_gain,
  input  logic [pp1d_pkg::node_cnt_w(NODE_COUNT)-1:0]   last_node,
  pp1d_result_if.source                                 result
);
  import pp1d_pkg::*;

  localparam int AW     = $clog2(NODE_COUNT);
  localparam int WGT_W  = FRAC_W + 1;
  localparam int GPROD_W = FIELD_W + WGT_W + 1;
  localparam int KPROD_W = GAIN_W + FIELD_W;
  localparam int KICK_W  = KPROD_W - 24;
  localparam int VSUM_W  = KICK_W + 1;
  localparam int PSUM_W  = VEL_W + 2;

  localparam logic signed [GPROD_W-1:0] GATHER_HALF = GPROD_W'(32768);
  localparam logic signed [KPROD_W-1:0] PUSH_HALF   = KPROD_W'(64'sd8388608);
  localparam logic signed [KPROD_W-1:0] REWIND_HALF = KPROD_W'(64'sd16777216);
  localparam logic signed [VSUM_W-1:0]  VEL_HI      = VSUM_W'(64'sd2147483647);
  localparam logic signed [VSUM_W-1:0]  VEL_LO      = VSUM_W'(-64'sd2147483648);
  localparam logic signed [PSUM_W-1:0]  POS_HI      = PSUM_W'((64'sd1 <<< POS_W) - 1);

  logic signed [FIELD_W-1:0] field_mem [NODE_COUNT];

  logic          adv;
  logic          issue;
  logic [AW-1:0] addr_lo;
  logic [AW-1:0] addr_hi;

  logic                       s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  kind_t                      s1_kind, s2_kind, s3_kind, s4_kind, s5_kind;
  logic [POS_W-1:0]           s1_pos, s2_pos, s3_pos, s4_pos, s5_pos;
  logic signed [VEL_W-1:0]    s1_vel, s2_vel, s3_vel, s4_vel, s5_vel;
  logic signed [FIELD_W-1:0]  rd_lo, rd_hi;
  logic signed [GPROD_W-1:0]  prod_lo, prod_hi;
  logic signed [FIELD_W-1:0]  s3_field;
  logic signed [KPROD_W-1:0]  s4_prod;

  logic [WGT_W-1:0]           wgt_lo;
  logic signed [GPROD_W-1:0]  gsum;
  logic signed [KPROD_W-1:0]  rnd_push;
  logic signed [KPROD_W-1:0]  rnd_rew;
  logic signed [KICK_W-1:0]   kick;
  logic signed [VSUM_W-1:0]   vsum;
  logic signed [VEL_W-1:0]    vel_new;
  logic signed [PSUM_W-1:0]   psum;
  logic signed [PSUM_W-1:0]   limit;
  logic [POS_W-1:0]           pos_out;
  logic                       absorbed_out;

  // whole pipeline moves when the output register is free
  assign adv   = !result.valid || result.ready;
  assign issue = head_valid && adv;
  assign pop   = issue;

  assign addr_lo = AW'(head.position[POS_W-1:FRAC_W]);
  assign addr_hi = addr_lo + AW'(1);

  always_ff @(posedge clk) begin
    if (issue && head.kind == KIND_WRITE) begin
      field_mem[AW'(head.node_index)] <= head.field_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_lo <= field_mem[addr_lo];
      rd_hi <= field_mem[addr_hi];
    end
  end

  // gather weights and sum
  assign wgt_lo = WGT_W'(17'h10000) - WGT_W'(s1_pos[FRAC_W-1:0]);
  assign gsum   = prod_lo + prod_hi + GATHER_HALF;

  // kick rounding
  assign rnd_push = s4_prod + PUSH_HALF;
  assign rnd_rew  = s4_prod + REWIND_HALF;

  always_comb begin
    kick    = rnd_push[KPROD_W-1:24];
    vsum    = VSUM_W'(s4_vel);
    vel_new = s4_vel;
    unique case (s4_kind)
      KIND_PUSH: begin
        kick = rnd_push[KPROD_W-1:24];
        vsum = VSUM_W'(s4_vel) + VSUM_W'(kick);
      end
      KIND_REWIND: begin
        kick = {rnd_rew[KPROD_W-1], rnd_rew[KPROD_W-1:25]};
        vsum = VSUM_W'(s4_vel) - VSUM_W'(kick);
      end
      default: begin
        kick = rnd_push[KPROD_W-1:24];
        vsum = VSUM_W'(s4_vel);
      end
    endcase
    if (vsum > VEL_HI) begin
      vel_new = VEL_HI[VEL_W-1:0];
    end else if (vsum < VEL_LO) begin
      vel_new = VEL_LO[VEL_W-1:0];
    end else begin
      vel_new = vsum[VEL_W-1:0];
    end
  end

  // drift and domain check
  assign psum  = PSUM_W'($signed({1'b0, s5_pos})) + PSUM_W'(s5_vel);
  assign limit = $signed(PSUM_W'({last_node, FRAC_W'(0)}));

  always_comb begin
    pos_out      = s5_pos;
    absorbed_out = 1'b0;
    unique case (s5_kind)
      KIND_PUSH: begin
        absorbed_out = (psum < 0) || (psum >= limit);
        if (psum < 0) begin
          pos_out = '0;
        end else if (psum > POS_HI) begin
          pos_out = POS_HI[POS_W-1:0];
        end else begin
          pos_out = psum[POS_W-1:0];
        end
      end
      KIND_PASS: begin
        pos_out      = s5_pos;
        absorbed_out = 1'b1;
      end
      default: begin
        pos_out      = s5_pos;
        absorbed_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= issue && head.kind != KIND_WRITE;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      result.valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= head.kind;
      s1_pos   <= head.position;
      s1_vel   <= head.velocity;

      s2_kind  <= s1_kind;
      s2_pos   <= s1_pos;
      s2_vel   <= s1_vel;
      prod_lo  <= GPROD_W'(rd_lo) * GPROD_W'($signed({1'b0, wgt_lo}));
      prod_hi  <= GPROD_W'(rd_hi) * GPROD_W'($signed({1'b0, s1_pos[FRAC_W-1:0]}));

      s3_kind  <= s2_kind;
      s3_pos   <= s2_pos;
      s3_vel   <= s2_vel;
      s3_field <= gsum[FIELD_W+FRAC_W-1:FRAC_W];

      s4_kind  <= s3_kind;
      s4_pos   <= s3_pos;
      s4_vel   <= s3_vel;
      s4_prod  <= KPROD_W'(s3_field) * KPROD_W'(accel_gain);

      s5_kind  <= s4_kind;
      s5_pos   <= s4_pos;
      s5_vel   <= vel_new;

      result.new_position <= pos_out;
      result.new_velocity <= s5_vel;
      result.absorbed     <= absorbed_out;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pic_particle_push_1d.sv =====
// ----------------------------------------------------------------------------
// pic_particle_push_1d
// throughput: one word per cycle unless the result output stalls, set by the
//   back pipeline issuing one queued word per cycle to the dual-read field
//   table and the single gain multiplier
// reset: clears the queue, pipeline valid bits and config (gain 0, nodes 401);
//   the field table is not cleared and holds nothing defined until written
// ----------------------------------------------------------------------------
`default_nettype none

module pic_particle_push_1d #(
  parameter int NODE_COUNT = pp1d_pkg::NODE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pp1d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pp1d_pkg::CFG_DATA_W-1:0]      cfg_data,
  pp1d_item_if.sink                            item,
  pp1d_result_if.source                        result
);
  import pp1d_pkg::*;

  localparam int CW = node_cnt_w(NODE_COUNT);

  logic signed [GAIN_W-1:0] accel_gain;
  logic [NODES_W-1:0]       nodes_in_use;
  logic [CW-1:0]            last_node;
  q_word_t                  head;
  logic                     head_valid;
  logic                     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain   <= '0;
      nodes_in_use <= NODES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_GAIN:   accel_gain   <= cfg_data[GAIN_W-1:0];
        REG_NODES_IN_USE: nodes_in_use <= cfg_data[NODES_W-1:0];
        default: ;
      endcase
    end
  end

  pp1d_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .nodes_in_use (nodes_in_use),
    .last_node    (last_node),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  pp1d_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .accel_gain (accel_gain),
    .last_node  (last_node),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== sv/pp1d_checker.sv =====
// ----------------------------------------------------------------------------
// pp1d_checker
// port-level checks on the particle push, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pp1d_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [pp1d_pkg::POS_W-1:0]         new_position,
  input logic [pp1d_pkg::VEL_W-1:0]         new_velocity,
  input logic                               absorbed
);
  import pp1d_pkg::*;

  `PP1D_ASSERT(a_result_held, clk, rst, result_valid && !result_ready |=> result_valid, "result word withdrawn while stalled")
  `PP1D_ASSERT(a_payload_held, clk, rst, result_valid && !result_ready |=> $stable(new_position) && $stable(new_velocity) && $stable(absorbed), "result word changed while stalled")
  `PP1D_ASSERT_ALWAYS(a_ready_after_reset, clk, rst |=> item_ready, "input not ready after reset")
  `PP1D_ASSERT_ALWAYS(a_no_early_result, clk, rst |=> !result_valid ##1 !result_valid ##1 !result_valid ##1 !result_valid ##1 !result_valid ##1 !result_valid, "result word sooner than the pipeline allows")

endmodule

bind pic_particle_push_1d pp1d_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .new_position (result.new_position),
  .new_velocity (result.new_velocity),
  .absorbed     (result.absorbed)
);

`default_nettype wire
